/* hw/rtl/bsp_pkg.sv */
// Shared types, constants and register codes for the billboard sprite projection.
package bsp_pkg;

   // Divider geometry: numerator, divisor and quotient widths
   localparam int NumW = 46;
   localparam int DivW = 38;
   localparam int QuoW = 21;
   localparam int NumTopW = NumW - QuoW;

   // Depth at or below this Q2.14 value is treated as behind the viewer
   localparam int NEAR_LIMIT = 1;

   // Division lanes
   localparam int LANE_LAT  = 0;
   localparam int LANE_DEP  = 1;
   localparam int LANE_COL  = 2;
   localparam int LANE_SIZE = 3;
   localparam int NumLanes  = 4;

   // Register indexes
   localparam logic [2:0] CSR_CAMERA_X     = 3'd0;
   localparam logic [2:0] CSR_CAMERA_Y     = 3'd1;
   localparam logic [2:0] CSR_DIR_X        = 3'd2;
   localparam logic [2:0] CSR_DIR_Y        = 3'd3;
   localparam logic [2:0] CSR_PLANE_X      = 3'd4;
   localparam logic [2:0] CSR_PLANE_Y      = 3'd5;
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd6;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd7;

   // Register reset values
   localparam logic signed [15:0] DIR_X_RESET   = -16'sd16384;
   localparam logic signed [15:0] PLANE_Y_RESET = 16'sd10813;
   localparam logic [11:0] FRAME_WIDTH_RESET    = 12'd640;
   localparam logic [11:0] FRAME_HEIGHT_RESET   = 12'd480;

   typedef struct packed {
      logic [15:0]        camera_x;
      logic [15:0]        camera_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] plane_x;
      logic signed [15:0] plane_y;
      logic [11:0]        frame_width;
      logic [11:0]        frame_height;
   } cfg_type;

   typedef struct packed {
      logic [15:0] sprite_x;
      logic [15:0] sprite_y;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic signed [15:0] lateral;
      logic signed [15:0] depth;
      logic signed [15:0] screen_column;
      logic [15:0]        sprite_extent;
      logic [11:0]        draw_start_x;
      logic [11:0]        draw_end_x;
      logic [11:0]        draw_start_y;
      logic [11:0]        draw_end_y;
   } rsp_type;

   // Partial remainder, divisor and numerator bits still to shift in
   typedef struct packed {
      logic [DivW-1:0] r;
      logic [DivW-1:0] d;
      logic [QuoW-1:0] n;
   } div_lane_type;

   // Sign and special-case flags that ride alongside the dividers
   typedef struct packed {
      logic                det_zero;
      logic                ny_zero;
      logic                lat_neg;
      logic                dep_neg;
      logic                col_neg;
      logic [NumLanes-1:0] ovf;
   } side_type;

endpackage

/* hw/rtl/bsp_div_cell.sv */
// One restoring divider cell: retires one quotient bit per clock.
module bsp_div_cell (
   input  logic                      clock,
   input  bsp_pkg::div_lane_type     lane_in,
   input  logic [bsp_pkg::QuoW-1:0]  q_in,
   output bsp_pkg::div_lane_type     lane_out,
   output logic [bsp_pkg::QuoW-1:0]  q_out
);
   import bsp_pkg::*;

   logic [DivW:0]  trial;
   logic           fits;
   div_lane_type   lane_ff, lane_in_next;
   logic [QuoW-1:0] q_ff, q_in_next;

   // Shift in the next numerator bit and try a subtract
   always_comb begin
      trial = {lane_in.r, lane_in.n[QuoW-1]};
      fits  = trial >= {1'b0, lane_in.d};
      lane_in_next.d = lane_in.d;
      lane_in_next.n = {lane_in.n[QuoW-2:0], 1'b0};
      if (fits) begin
         lane_in_next.r = DivW'(trial - {1'b0, lane_in.d});
      end else begin
         lane_in_next.r = trial[DivW-1:0];
      end
      q_in_next = {q_in[QuoW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in_next;
      q_ff    <= q_in_next;
   end

   assign lane_out = lane_ff;
   assign q_out    = q_ff;

endmodule

/* hw/rtl/bsp_div_lane.sv */
// Chain of divider cells giving one truncated quotient per clock.
module bsp_div_lane (
   input  logic                      clock,
   input  bsp_pkg::div_lane_type     lane_in,
   output logic [bsp_pkg::QuoW-1:0]  q_out
);
   import bsp_pkg::*;

   div_lane_type    lane_w [QuoW+1];
   logic [QuoW-1:0] q_w    [QuoW+1];

   assign lane_w[0] = lane_in;
   assign q_w[0]    = '0;

   // Hand remainder and quotient from cell to cell
   for (genvar i = 0; i < QuoW; i++) begin : g_cell
      bsp_div_cell u_cell (
         .clock    (clock),
         .lane_in  (lane_w[i]),
         .q_in     (q_w[i]),
         .lane_out (lane_w[i+1]),
         .q_out    (q_w[i+1])
      );
   end

   assign q_out = q_w[QuoW];

endmodule

/* hw/rtl/bsp_front.sv */
// Camera transform front end: offsets, products, magnitudes and divider setup.
module bsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  bsp_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   input  bsp_pkg::req_type      in_data,
   output logic                  out_valid,
   output bsp_pkg::side_type     out_side,
   output bsp_pkg::div_lane_type out_lane [bsp_pkg::NumLanes]
);
   import bsp_pkg::*;

   function automatic logic [32:0] mag34(input logic signed [33:0] v);
      logic signed [33:0] a;
      a = v[33] ? -v : v;
      return a[32:0];
   endfunction

   // Stage A: camera-relative offsets
   logic               a_valid_ff;
   logic signed [16:0] a_dx_ff, a_dy_ff;
   // Stage B: products
   logic               b_valid_ff;
   logic signed [32:0] b_p1_ff, b_p2_ff, b_p3_ff, b_p4_ff;
   logic signed [31:0] b_d1_ff, b_d2_ff;
   // Stage C: transformed coordinates and determinant
   logic               c_valid_ff;
   logic signed [32:0] c_nx_ff, c_ny_ff;
   logic signed [31:0] c_det_ff;
   // Stage D: magnitudes and signs
   logic               d_valid_ff;
   logic [31:0]        d_nxm_ff, d_nym_ff, d_detm_ff;
   logic [32:0]        d_sm_ff;
   side_type           d_side_ff, d_side_in;
   logic signed [33:0] s_w;
   logic [32:0]        nxm_w, nym_w, detm_w;
   // Stage E: numerators and divisors
   logic               e_valid_ff;
   logic [NumW-1:0]    e_n_ff [NumLanes];
   logic [DivW-1:0]    e_d_ff [NumLanes];
   side_type           e_side_ff;
   logic [10:0]        half_w;
   // Stage F: divider entry
   logic               f_valid_ff;
   side_type           f_side_ff, f_side_in;
   div_lane_type       f_lane_ff [NumLanes];
   logic [NumLanes-1:0] ovf_w;

   // Advance valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   // Subtract the camera position
   always_ff @(posedge clock) begin
      a_dx_ff <= $signed({1'b0, in_data.sprite_x}) - $signed({1'b0, cfg.camera_x});
      a_dy_ff <= $signed({1'b0, in_data.sprite_y}) - $signed({1'b0, cfg.camera_y});
   end

   // Multiply by the camera matrix terms
   always_ff @(posedge clock) begin
      b_p1_ff <= 33'(cfg.dir_y) * 33'(a_dx_ff);
      b_p2_ff <= 33'(cfg.dir_x) * 33'(a_dy_ff);
      b_p3_ff <= 33'(cfg.plane_x) * 33'(a_dy_ff);
      b_p4_ff <= 33'(cfg.plane_y) * 33'(a_dx_ff);
      b_d1_ff <= 32'(cfg.plane_x) * 32'(cfg.dir_y);
      b_d2_ff <= 32'(cfg.dir_x) * 32'(cfg.plane_y);
   end

   // Combine products
   always_ff @(posedge clock) begin
      c_nx_ff  <= b_p1_ff - b_p2_ff;
      c_ny_ff  <= b_p3_ff - b_p4_ff;
      c_det_ff <= b_d1_ff - b_d2_ff;
   end

   // Split into sign and magnitude
   always_comb begin
      s_w    = 34'(c_nx_ff) + 34'(c_ny_ff);
      nxm_w  = mag34(34'(c_nx_ff));
      nym_w  = mag34(34'(c_ny_ff));
      detm_w = mag34(34'(c_det_ff));
      d_side_in.det_zero = c_det_ff == '0;
      d_side_in.ny_zero  = c_ny_ff == '0;
      d_side_in.lat_neg  = c_nx_ff[32] ^ c_det_ff[31];
      d_side_in.dep_neg  = c_ny_ff[32] ^ c_det_ff[31];
      d_side_in.col_neg  = s_w[33] ^ c_ny_ff[32];
      d_side_in.ovf      = '0;
   end

   always_ff @(posedge clock) begin
      d_nxm_ff  <= nxm_w[31:0];
      d_nym_ff  <= nym_w[31:0];
      d_detm_ff <= detm_w[31:0];
      d_sm_ff   <= mag34(s_w);
      d_side_ff <= d_side_in;
   end

   // Form numerators and divisors
   assign half_w = cfg.frame_width[11:1];

   always_ff @(posedge clock) begin
      e_n_ff[LANE_LAT]  <= NumW'({d_nxm_ff, 14'd0});
      e_n_ff[LANE_DEP]  <= NumW'({d_nym_ff, 14'd0});
      e_n_ff[LANE_COL]  <= NumW'(44'(half_w) * 44'(d_sm_ff));
      e_n_ff[LANE_SIZE] <= NumW'(44'(cfg.frame_height) * 44'(d_detm_ff));
      e_d_ff[LANE_LAT]  <= DivW'(d_detm_ff);
      e_d_ff[LANE_DEP]  <= DivW'(d_detm_ff);
      e_d_ff[LANE_COL]  <= DivW'(d_nym_ff);
      e_d_ff[LANE_SIZE] <= {d_nym_ff, 6'd0};
      e_side_ff         <= d_side_ff;
   end

   // Flag quotients that overflow the divider and load the first remainder
   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         ovf_w[i] = DivW'(e_n_ff[i][NumW-1:QuoW]) >= e_d_ff[i];
      end
      f_side_in     = e_side_ff;
      f_side_in.ovf = ovf_w;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NumLanes; i++) begin
         f_lane_ff[i].r <= DivW'(e_n_ff[i][NumW-1:QuoW]);
         f_lane_ff[i].d <= e_d_ff[i];
         f_lane_ff[i].n <= e_n_ff[i][QuoW-1:0];
      end
      f_side_ff <= f_side_in;
   end

   assign out_valid = f_valid_ff;
   assign out_side  = f_side_ff;
   assign out_lane  = f_lane_ff;

endmodule

/* hw/rtl/bsp_back.sv */
// Back end: signs, saturation, visibility and clamped draw bounds.
module bsp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  bsp_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   input  bsp_pkg::side_type        in_side,
   input  logic [bsp_pkg::QuoW-1:0] in_q [bsp_pkg::NumLanes],
   output logic                     out_valid,
   output bsp_pkg::rsp_type         out_data
);
   import bsp_pkg::*;

   function automatic logic signed [15:0] sat16(input logic neg, input logic ovf,
                                                input logic [QuoW-1:0] q);
      logic signed [15:0] v;
      if (neg) begin
         v = (ovf || q > QuoW'(32768)) ? -16'sd32768 : -$signed(q[15:0]);
      end else begin
         v = (ovf || q > QuoW'(32767)) ? 16'sd32767 : $signed(q[15:0]);
      end
      return v;
   endfunction

   // Stage P1
   logic               p_valid_ff, p_vis_ff;
   logic signed [15:0] p_lat_ff, p_dep_ff;
   logic signed [22:0] p_col_ff;
   logic [QuoW-1:0]    p_size_ff;
   logic [QuoW-2:0]    p_half_ff;
   logic               dep_gt_w, vis_w;
   logic [QuoW:0]      colm_w;
   logic [QuoW-1:0]    size_w;
   // Stage P2 (result register)
   logic               r_valid_ff;
   rsp_type            r_data_ff, r_data_in;
   logic [10:0]        hh_w;
   logic [QuoW-1:0]    ey_sum_w;
   logic signed [23:0] sx_w, ex_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
         r_valid_ff <= p_valid_ff;
      end
   end

   // Apply signs and decide visibility
   always_comb begin
      dep_gt_w = !in_side.dep_neg &&
                 (in_side.ovf[LANE_DEP] || in_q[LANE_DEP] > QuoW'(NEAR_LIMIT));
      vis_w    = !in_side.det_zero && !in_side.ny_zero && dep_gt_w;
      colm_w   = in_side.ovf[LANE_COL] ? (QuoW+1)'(1 << QuoW) : {1'b0, in_q[LANE_COL]};
      size_w   = in_side.ovf[LANE_SIZE] ? '1 : in_q[LANE_SIZE];
   end

   always_ff @(posedge clock) begin
      p_vis_ff  <= vis_w;
      p_lat_ff  <= in_side.det_zero ? '0 :
                   sat16(in_side.lat_neg, in_side.ovf[LANE_LAT], in_q[LANE_LAT]);
      p_dep_ff  <= in_side.det_zero ? '0 :
                   sat16(in_side.dep_neg, in_side.ovf[LANE_DEP], in_q[LANE_DEP]);
      p_col_ff  <= in_side.col_neg ? -$signed({1'b0, colm_w}) : $signed({1'b0, colm_w});
      p_size_ff <= size_w;
      p_half_ff <= size_w[QuoW-1:1];
   end

   // Clamp column, size and draw bounds
   always_comb begin
      hh_w     = cfg.frame_height[11:1];
      ey_sum_w = QuoW'(hh_w) + QuoW'(p_half_ff);
      sx_w     = 24'(p_col_ff) - $signed({4'd0, p_half_ff});
      ex_w     = 24'(p_col_ff) + $signed({4'd0, p_half_ff});
      r_data_in         = '0;
      r_data_in.lateral = p_lat_ff;
      r_data_in.depth   = p_dep_ff;
      if (p_vis_ff) begin
         r_data_in.visible = 1'b1;
         if (p_col_ff > 23'sd32767) begin
            r_data_in.screen_column = 16'sd32767;
         end else if (p_col_ff < -23'sd32768) begin
            r_data_in.screen_column = -16'sd32768;
         end else begin
            r_data_in.screen_column = p_col_ff[15:0];
         end
         r_data_in.sprite_extent = (p_size_ff > QuoW'(65535)) ? 16'hFFFF : p_size_ff[15:0];
         if (p_half_ff >= (QuoW-1)'(hh_w)) begin
            r_data_in.draw_start_y = '0;
         end else begin
            r_data_in.draw_start_y = {1'b0, hh_w - p_half_ff[10:0]};
         end
         if (cfg.frame_height == '0) begin
            r_data_in.draw_end_y = '0;
         end else if (ey_sum_w > QuoW'(cfg.frame_height - 12'd1)) begin
            r_data_in.draw_end_y = cfg.frame_height - 12'd1;
         end else begin
            r_data_in.draw_end_y = ey_sum_w[11:0];
         end
         if (sx_w < 0) begin
            r_data_in.draw_start_x = '0;
         end else if (sx_w > 24'sd4095) begin
            r_data_in.draw_start_x = 12'd4095;
         end else begin
            r_data_in.draw_start_x = sx_w[11:0];
         end
         if (ex_w > $signed({12'd0, cfg.frame_width})) begin
            r_data_in.draw_end_x = cfg.frame_width;
         end else if (ex_w < 0) begin
            r_data_in.draw_end_x = '0;
         end else begin
            r_data_in.draw_end_x = ex_w[11:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      r_data_ff <= r_data_in;
   end

   assign out_valid = r_valid_ff;
   assign out_data  = r_data_ff;

endmodule

/* hw/rtl/billboard_sprite_projection.sv */
// Top level of the billboard sprite projection: registers, divider lanes, flag delay line.
//
// Projects one sprite world position per clock into camera space and screen bounds.
// busy stays low, so a transaction is taken on every cycle that start is high. Each
// result appears on rsp_data with rsp_valid high for one cycle, through 29 register stages
// from the accepting edge; the receiver must take it then. Most stages lie in the four
// 21-cell divider chains (lateral, depth, column, size), one quotient bit per cell; six
// front stages and two back stages make up the rest. Registers are written through
// csr_we/csr_index/csr_wdata and should change only while no sprite is in flight.
module billboard_sprite_projection (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bsp_pkg::req_type  req_data,
   output logic              rsp_valid,
   output bsp_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import bsp_pkg::*;

   cfg_type         cfg_ff;
   logic            front_valid;
   side_type        front_side;
   div_lane_type    front_lane [NumLanes];
   logic [QuoW-1:0] lane_q     [NumLanes];
   logic [QuoW-1:0] valid_ff;
   side_type        side_ff    [QuoW];

   assign busy = 1'b0;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x     <= '0;
         cfg_ff.camera_y     <= '0;
         cfg_ff.dir_x        <= DIR_X_RESET;
         cfg_ff.dir_y        <= '0;
         cfg_ff.plane_x      <= '0;
         cfg_ff.plane_y      <= PLANE_Y_RESET;
         cfg_ff.frame_width  <= FRAME_WIDTH_RESET;
         cfg_ff.frame_height <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAMERA_X:     cfg_ff.camera_x     <= csr_wdata;
            CSR_CAMERA_Y:     cfg_ff.camera_y     <= csr_wdata;
            CSR_DIR_X:        cfg_ff.dir_x        <= $signed(csr_wdata);
            CSR_DIR_Y:        cfg_ff.dir_y        <= $signed(csr_wdata);
            CSR_PLANE_X:      cfg_ff.plane_x      <= $signed(csr_wdata);
            CSR_PLANE_Y:      cfg_ff.plane_y      <= $signed(csr_wdata);
            CSR_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_wdata[11:0];
            CSR_FRAME_HEIGHT: cfg_ff.frame_height <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   bsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_lane  (front_lane)
   );

   for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      bsp_div_lane u_lane (
         .clock   (clock),
         .lane_in (front_lane[l]),
         .q_out   (lane_q[l])
      );
   end

   // Advance valid and flags alongside the divider cells
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[QuoW-2:0], front_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= front_side;
      for (int i = 1; i < QuoW; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   bsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (valid_ff[QuoW-1]),
      .in_side   (side_ff[QuoW-1]),
      .in_q      (lane_q),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the billboard sprite projection block.
module tb;
   import bsp_pkg::*;

   // Predicts the camera-space projection of each sprite and checks results in order
   class projection_scoreboard;
      rsp_type pending_q[$];
      int errors;
      int checked;
      cfg_type cam;

      function new();
         errors = 0;
         checked = 0;
      endfunction

      function longint sat(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // Work out the projection of one accepted sprite and queue it
      function void note_sprite(req_type s);
         longint dx, dy, drx, dry, plx, ply, w, h, det, nx, ny;
         longint lat, dep, col, sz, half, sx, ex, sy, ey;
         rsp_type r;
         r = '0;
         dx = longint'(s.sprite_x) - longint'(cam.camera_x);
         dy = longint'(s.sprite_y) - longint'(cam.camera_y);
         drx = cam.dir_x;
         dry = cam.dir_y;
         plx = cam.plane_x;
         ply = cam.plane_y;
         w = cam.frame_width;
         h = cam.frame_height;
         det = plx * dry - drx * ply;
         nx = dry * dx - drx * dy;
         ny = plx * dy - ply * dx;
         if (det != 0) begin
            lat = (nx * 16384) / det;
            dep = (ny * 16384) / det;
            r.lateral = 16'(sat(lat, -32768, 32767));
            r.depth = 16'(sat(dep, -32768, 32767));
            if (dep > NEAR_LIMIT && ny != 0) begin
               col = ((w / 2) * (ny + nx)) / ny;
               sz = (h * det) / (ny * 64);
               if (sz < 0) sz = -sz;
               half = sz / 2;
               sy = sat(h / 2 - half, 0, 4095);
               ey = h / 2 + half;
               if (ey > h - 1) ey = h - 1;
               ey = sat(ey, 0, 4095);
               sx = sat(col - half, 0, 4095);
               ex = col + half;
               if (ex > w) ex = w;
               ex = sat(ex, 0, 4095);
               r.visible = 1'b1;
               r.screen_column = 16'(sat(col, -32768, 32767));
               r.sprite_extent = 16'(sat(sz, 0, 65535));
               r.draw_start_x = 12'(sx);
               r.draw_end_x = 12'(ex);
               r.draw_start_y = 12'(sy);
               r.draw_end_y = 12'(ey);
            end
         end
         pending_q.push_back(r);
      endfunction

      function void report(string f, longint e, longint a);
         $display("%0t: %s expected %0d actual %0d", $time, f, e, a);
         errors++;
      endfunction

      // Compare one result against the oldest expectation
      function void check_result(rsp_type a);
         rsp_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, a);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         checked++;
         if (a.visible !== e.visible)
            report("visible", longint'(e.visible), longint'(a.visible));
         if (a.lateral !== e.lateral)
            report("lateral", longint'(e.lateral), longint'(a.lateral));
         if (a.depth !== e.depth)
            report("depth", longint'(e.depth), longint'(a.depth));
         if (a.screen_column !== e.screen_column)
            report("screen_column", longint'(e.screen_column), longint'(a.screen_column));
         if (a.sprite_extent !== e.sprite_extent)
            report("sprite_extent", longint'(e.sprite_extent), longint'(a.sprite_extent));
         if (a.draw_start_x !== e.draw_start_x)
            report("draw_start_x", longint'(e.draw_start_x), longint'(a.draw_start_x));
         if (a.draw_end_x !== e.draw_end_x)
            report("draw_end_x", longint'(e.draw_end_x), longint'(a.draw_end_x));
         if (a.draw_start_y !== e.draw_start_y)
            report("draw_start_y", longint'(e.draw_start_y), longint'(a.draw_start_y));
         if (a.draw_end_y !== e.draw_end_y)
            report("draw_end_y", longint'(e.draw_end_y), longint'(a.draw_end_y));
      endfunction
   endclass

   localparam int WatchdogLimit = 2000;
   localparam int Latency = 29;

   logic clock, reset, start, busy, rsp_valid, csr_we;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;
   req_type req_data;
   rsp_type rsp_data;
   projection_scoreboard sb;
   int idle_cycles;
   int sprites_sent;
   bit allow_gaps;

   billboard_sprite_projection dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Check results and watch for a stalled run
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_data);
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog expired with %0d results pending", sb.pending_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Write one register and mirror it in the predictor
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CAMERA_X:     sb.cam.camera_x = val;
         CSR_CAMERA_Y:     sb.cam.camera_y = val;
         CSR_DIR_X:        sb.cam.dir_x = val;
         CSR_DIR_Y:        sb.cam.dir_y = val;
         CSR_PLANE_X:      sb.cam.plane_x = val;
         CSR_PLANE_Y:      sb.cam.plane_y = val;
         CSR_FRAME_WIDTH:  sb.cam.frame_width = val[11:0];
         CSR_FRAME_HEIGHT: sb.cam.frame_height = val[11:0];
         default: ;
      endcase
   endtask

   // Send one sprite transaction, with an occasional gap before it
   task automatic send_sprite(logic [15:0] x, logic [15:0] y);
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{sprite_x: x, sprite_y: y};
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_sprite('{sprite_x: x, sprite_y: y});
      sprites_sent++;
      @(negedge clock);
   endtask

   // Let every transaction in flight drain
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (Latency + 4) @(negedge clock);
   endtask

   // Sprites near the camera so most land in front and on screen
   task automatic send_near(int n);
      logic [15:0] x, y;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            x = 16'($urandom);
            y = 16'($urandom);
         end else begin
            x = sb.cam.camera_x + 16'($signed($urandom_range(0, 8191)) - 4096);
            y = sb.cam.camera_y + 16'($signed($urandom_range(0, 8191)) - 4096);
         end
         send_sprite(x, y);
      end
   endtask

   // Random camera with random position, orientation and frame size
   task automatic random_camera();
      int a;
      write_reg(CSR_CAMERA_X, 16'($urandom));
      write_reg(CSR_CAMERA_Y, 16'($urandom));
      a = $urandom_range(0, 3);
      if (a == 0) begin
         write_reg(CSR_DIR_X, 16'($urandom));
         write_reg(CSR_DIR_Y, 16'($urandom));
         write_reg(CSR_PLANE_X, 16'($urandom));
         write_reg(CSR_PLANE_Y, 16'($urandom));
      end else begin
         write_reg(CSR_DIR_X, 16'($signed($urandom_range(0, 32767)) - 16384));
         write_reg(CSR_DIR_Y, 16'($signed($urandom_range(0, 32767)) - 16384));
         write_reg(CSR_PLANE_X, 16'($signed($urandom_range(0, 21625)) - 10813));
         write_reg(CSR_PLANE_Y, 16'($signed($urandom_range(0, 21625)) - 10813));
      end
      write_reg(CSR_FRAME_WIDTH, 16'($urandom_range(0, 4095)));
      write_reg(CSR_FRAME_HEIGHT, 16'($urandom_range(0, 4095)));
   endtask

   initial begin
      sb = new();
      sb.cam = '{camera_x: 16'd0, camera_y: 16'd0, dir_x: DIR_X_RESET, dir_y: 16'sd0,
                 plane_x: 16'sd0, plane_y: PLANE_Y_RESET,
                 frame_width: FRAME_WIDTH_RESET, frame_height: FRAME_HEIGHT_RESET};
      idle_cycles = 0;
      sprites_sent = 0;
      allow_gaps = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_CAMERA_X;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: reset camera, field extremes, behind and ahead of viewer
      send_sprite(16'h0000, 16'h0000);
      send_sprite(16'hFFFF, 16'hFFFF);
      send_sprite(16'h0000, 16'hFFFF);
      send_sprite(16'hFFFF, 16'h0000);
      drain();
      write_reg(CSR_CAMERA_X, 16'h8000);
      write_reg(CSR_CAMERA_Y, 16'h8000);
      send_sprite(16'h7C00, 16'h8000);
      send_sprite(16'h7FFF, 16'h8000);
      send_sprite(16'h7F00, 16'h8000);
      send_sprite(16'h7F00, 16'h9000);
      send_sprite(16'h7F00, 16'h6000);
      send_sprite(16'h8400, 16'h8000);
      send_sprite(16'h8000, 16'h8000);
      send_sprite(16'h7FF0, 16'h8000);
      drain();
      // Zero frame height and tiny width
      write_reg(CSR_FRAME_HEIGHT, 16'd0);
      write_reg(CSR_FRAME_WIDTH, 16'd1);
      send_sprite(16'h7C00, 16'h8000);
      send_sprite(16'h7F80, 16'h8100);
      drain();
      // Zero determinant
      write_reg(CSR_FRAME_WIDTH, 16'd4095);
      write_reg(CSR_FRAME_HEIGHT, 16'd4095);
      write_reg(CSR_PLANE_Y, 16'd0);
      send_sprite(16'h7C00, 16'h8000);
      send_sprite(16'h1234, 16'hABCD);
      drain();
      // Extreme orientation values
      write_reg(CSR_DIR_X, 16'h8000);
      write_reg(CSR_DIR_Y, 16'h7FFF);
      write_reg(CSR_PLANE_X, 16'h7FFF);
      write_reg(CSR_PLANE_Y, 16'h8000);
      send_sprite(16'h0000, 16'hFFFF);
      send_sprite(16'hFFFF, 16'h0000);
      send_sprite(16'h8001, 16'h7FFF);
      drain();

      // Random phases, each under a fresh camera
      allow_gaps = 1'b1;
      for (int p = 0; p < 20; p++) begin
         random_camera();
         send_near(55);
         drain();
      end
      // Closing phase at full rate
      allow_gaps = 1'b0;
      write_reg(CSR_FRAME_WIDTH, 16'd4095);
      write_reg(CSR_FRAME_HEIGHT, 16'd1);
      send_near(30);
      drain();

      $display("sent %0d sprites through directed corner cameras, 20 random cameras",
               sprites_sent);
      $display("and a full-rate closing burst; %0d results checked", sb.checked);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

/* billboard_sprite_projection.f */
hw/rtl/bsp_pkg.sv
hw/rtl/bsp_div_cell.sv
hw/rtl/bsp_div_lane.sv
hw/rtl/bsp_front.sv
hw/rtl/bsp_back.sv
hw/rtl/billboard_sprite_projection.sv
verif/tb.sv
